### rtl/core/prf_pkg.sv
// ----------------------------------------------------------------------------
// prf_pkg: shared types and constants of the pixel region fade block
// Holds the payload structs, the configuration register map and the
// pixel format codes used by the front, queue and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

package prf_pkg;

  // Frame size limits, used as defaults for the top-level parameters.
  localparam int MAX_FRAME_WIDTH_DEF  = 4096;
  localparam int MAX_FRAME_HEIGHT_DEF = 4096;

  // Configuration port geometry.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 13;

  // Fade factor that disables fading.
  localparam logic [8:0] FADE_NONE = 9'd256;

  // Register map of the configuration port.
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_DEPTH_MODE   = 3'd0,
    REG_FADE_FACTOR  = 3'd1,
    REG_FRAME_WIDTH  = 3'd2,
    REG_FRAME_HEIGHT = 3'd3,
    REG_RECT_X       = 3'd4,
    REG_RECT_Y       = 3'd5,
    REG_RECT_WIDTH   = 3'd6,
    REG_RECT_HEIGHT  = 3'd7
  } cfg_reg_t;

  // Pixel formats.
  typedef enum logic [1:0] {
    DEPTH_RGB332   = 2'd0,
    DEPTH_RGB555   = 2'd1,
    DEPTH_RGB565   = 2'd2,
    DEPTH_ARGB8888 = 2'd3
  } depth_mode_t;

  // Reset values of the frame size registers.
  localparam logic [12:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [12:0] FRAME_HEIGHT_RST = 13'd480;

  // Configuration as seen by the front and back parts.
  typedef struct packed {
    depth_mode_t        depth_mode;
    logic [8:0]         fade_factor;
    logic [12:0]        frame_width;
    logic [12:0]        frame_height;
    logic signed [12:0] rect_x;
    logic signed [12:0] rect_y;
    logic [12:0]        rect_width;
    logic [12:0]        rect_height;
  } prf_cfg_t;

  // Input request.
  typedef struct packed {
    logic [31:0] pixel_in;
    logic        frame_start;
  } pixel_in_t;

  // Result request.
  typedef struct packed {
    logic [31:0] pixel_out;
    logic        in_region;
    logic        frame_last;
  } pixel_out_t;

  // Classified pixel handed from the front to the back.
  typedef struct packed {
    logic [31:0] pixel;
    logic        fade;
    logic        in_region;
    logic        frame_last;
  } prf_job_t;

endpackage : prf_pkg

`default_nettype wire

### rtl/core/pixel_region_fade.sv
// ----------------------------------------------------------------------------
// pixel_region_fade: brightness fade of a rectangular frame region
// Top level: configuration registers, front classifier, queue and back end.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock in raster order while full is low
// and returns one result per pixel, in order, at one pixel per clock
// sustained while the consumer keeps up. An accepted pixel is written
// into a queue slot and then loaded into the result register, which
// drives the result ports, once that register is free or being popped.
// In steady flow the two-entry queue between the position tracker and
// the scaler holds one pixel, so a consumer stall lets one more pixel in
// and then blocks the input: full rises only when both queue entries and
// the result register hold pixels.
// Registers must be written only while no pixel is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_region_fade #(
  parameter int MAX_FRAME_WIDTH  = prf_pkg::MAX_FRAME_WIDTH_DEF,
  parameter int MAX_FRAME_HEIGHT = prf_pkg::MAX_FRAME_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  prf_pkg::pixel_in_t              in_data,
  output logic                            empty,
  input  logic                            pop,
  output prf_pkg::pixel_out_t             out_data,
  input  logic                            cfg_we,
  input  logic [prf_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [prf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import prf_pkg::*;

  prf_cfg_t cfg_r;
  prf_job_t front_job, back_job;
  logic     accept;
  logic     q_full, q_empty, q_pop;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.depth_mode   <= DEPTH_ARGB8888;
      cfg_r.fade_factor  <= FADE_NONE;
      cfg_r.frame_width  <= FRAME_WIDTH_RST;
      cfg_r.frame_height <= FRAME_HEIGHT_RST;
      cfg_r.rect_x       <= '0;
      cfg_r.rect_y       <= '0;
      cfg_r.rect_width   <= '0;
      cfg_r.rect_height  <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_DEPTH_MODE:   cfg_r.depth_mode   <= depth_mode_t'(cfg_wdata[1:0]);
        REG_FADE_FACTOR:  cfg_r.fade_factor  <= cfg_wdata[8:0];
        REG_FRAME_WIDTH:  cfg_r.frame_width  <= cfg_wdata;
        REG_FRAME_HEIGHT: cfg_r.frame_height <= cfg_wdata;
        REG_RECT_X:       cfg_r.rect_x       <= $signed(cfg_wdata);
        REG_RECT_Y:       cfg_r.rect_y       <= $signed(cfg_wdata);
        REG_RECT_WIDTH:   cfg_r.rect_width   <= cfg_wdata;
        REG_RECT_HEIGHT:  cfg_r.rect_height  <= cfg_wdata;
        default:          cfg_r              <= cfg_r;
      endcase
    end
  end

  // Input handshake.
  assign full   = q_full;
  assign accept = push && !q_full;

  prf_front #(
    .MAX_FRAME_WIDTH  (MAX_FRAME_WIDTH),
    .MAX_FRAME_HEIGHT (MAX_FRAME_HEIGHT)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_data (in_data),
    .accept  (accept),
    .job     (front_job)
  );

  prf_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (accept),
    .job_in  (front_job),
    .full    (q_full),
    .pop     (q_pop),
    .job_out (back_job),
    .empty   (q_empty)
  );

  prf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .job       (back_job),
    .job_empty (q_empty),
    .job_pop   (q_pop),
    .out_data  (out_data),
    .empty     (empty),
    .pop       (pop)
  );

endmodule : pixel_region_fade

`default_nettype wire

### rtl/core/prf_front.sv
// ----------------------------------------------------------------------------
// prf_front: raster position tracking and region classification
// Keeps the column and row counters, clips the fade rectangle to the frame
// and tags each accepted pixel with its region and end-of-frame flags.
// ----------------------------------------------------------------------------
`default_nettype none

module prf_front #(
  parameter int MAX_FRAME_WIDTH  = prf_pkg::MAX_FRAME_WIDTH_DEF,
  parameter int MAX_FRAME_HEIGHT = prf_pkg::MAX_FRAME_HEIGHT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  prf_pkg::prf_cfg_t   cfg,
  input  prf_pkg::pixel_in_t  in_data,
  input  logic                accept,
  output prf_pkg::prf_job_t   job
);
  import prf_pkg::*;

  localparam int CW = $clog2(MAX_FRAME_WIDTH);
  localparam int RW = $clog2(MAX_FRAME_HEIGHT);
  localparam int DW = (CW > RW) ? CW : RW;
  localparam int SW = ((DW > 14) ? DW : 14) + 2;

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [CW:0]   eff_w;
  logic [RW:0]   eff_h;
  logic signed [SW-1:0] x0, x1, y0, y1, rx, ry, x_end, y_end, wx, hy, colx, rowx;
  logic in_rect, last_col, last_row;

  // Frame size, saturated to the limits; zero acts as one.
  always_comb begin
    if (cfg.frame_width == '0) begin
      eff_w = (CW+1)'(1);
    end else if (32'(cfg.frame_width) > 32'(MAX_FRAME_WIDTH)) begin
      eff_w = (CW+1)'(MAX_FRAME_WIDTH);
    end else begin
      eff_w = (CW+1)'(cfg.frame_width);
    end
    if (cfg.frame_height == '0) begin
      eff_h = (RW+1)'(1);
    end else if (32'(cfg.frame_height) > 32'(MAX_FRAME_HEIGHT)) begin
      eff_h = (RW+1)'(MAX_FRAME_HEIGHT);
    end else begin
      eff_h = (RW+1)'(cfg.frame_height);
    end
  end

  // Rectangle clipped to the frame.
  always_comb begin
    rx    = {{(SW-13){cfg.rect_x[12]}}, cfg.rect_x};
    ry    = {{(SW-13){cfg.rect_y[12]}}, cfg.rect_y};
    wx    = {{(SW-CW-1){1'b0}}, eff_w};
    hy    = {{(SW-RW-1){1'b0}}, eff_h};
    x_end = rx + {{(SW-13){1'b0}}, cfg.rect_width};
    y_end = ry + {{(SW-13){1'b0}}, cfg.rect_height};
    x0    = cfg.rect_x[12] ? '0 : rx;
    y0    = cfg.rect_y[12] ? '0 : ry;
    x1    = (x_end > wx) ? wx : x_end;
    y1    = (y_end > hy) ? hy : y_end;
  end

  // Position of this pixel and its classification.
  always_comb begin
    col      = in_data.frame_start ? '0 : col_r;
    row      = in_data.frame_start ? '0 : row_r;
    colx     = {{(SW-CW){1'b0}}, col};
    rowx     = {{(SW-RW){1'b0}}, row};
    in_rect  = (cfg.rect_width != '0) && (cfg.rect_height != '0) &&
               (colx >= x0) && (colx < x1) && (rowx >= y0) && (rowx < y1);
    last_col = {1'b0, col} >= (eff_w - (CW+1)'(1));
    last_row = {1'b0, row} >= (eff_h - (RW+1)'(1));
  end

  // Counter advance, wrapping at the end of a row and of the frame.
  always_comb begin
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row + RW'(1);
    end else begin
      col_nxt = col + CW'(1);
      row_nxt = row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Classified pixel for the queue.
  always_comb begin
    job.pixel      = in_data.pixel_in;
    job.fade       = in_rect && (cfg.fade_factor < FADE_NONE);
    job.in_region  = in_rect;
    job.frame_last = last_col && last_row;
  end

endmodule : prf_front

`default_nettype wire

### rtl/core/prf_queue.sv
// ----------------------------------------------------------------------------
// prf_queue: two-entry queue between the front and the back
// Lets the front keep accepting pixels while the back stalls, until both entries are taken.
// ----------------------------------------------------------------------------
`default_nettype none

module prf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  prf_pkg::prf_job_t job_in,
  output logic              full,
  input  logic              pop,
  output prf_pkg::prf_job_t job_out,
  output logic              empty
);
  import prf_pkg::*;

  prf_job_t   slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign job_out = slot_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= job_in;
    end
  end

endmodule : prf_queue

`default_nettype wire

### rtl/core/prf_back.sv
// ----------------------------------------------------------------------------
// prf_back: color scaling and result register
// Widens each color field to 8 bits, scales it by the fade factor, packs
// it back into the current format and holds the result for the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module prf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  prf_pkg::prf_cfg_t   cfg,
  input  prf_pkg::prf_job_t   job,
  input  logic                job_empty,
  output logic                job_pop,
  output prf_pkg::pixel_out_t out_data,
  output logic                empty,
  input  logic                pop
);
  import prf_pkg::*;

  pixel_out_t  out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        advance;
  logic [7:0]  r8, g8, b8, f8;
  logic [15:0] r_prod, g_prod, b_prod;
  logic [7:0]  rs, gs, bs;
  logic [31:0] faded;
  logic [31:0] p;

  // Take the next job when the result register is free or being drained.
  assign advance       = !job_empty && (!out_valid_r || pop);
  assign job_pop       = advance;
  assign out_valid_nxt = advance || (out_valid_r && !pop);

  // Widen the color fields to the top of a byte.
  always_comb begin
    p = job.pixel;
    case (cfg.depth_mode)
      DEPTH_RGB332: begin
        r8 = {p[7:5], 5'd0};
        g8 = {p[4:2], 5'd0};
        b8 = {p[1:0], 6'd0};
      end
      DEPTH_RGB555: begin
        r8 = {p[14:10], 3'd0};
        g8 = {p[9:5], 3'd0};
        b8 = {p[4:0], 3'd0};
      end
      DEPTH_RGB565: begin
        r8 = {p[15:11], 3'd0};
        g8 = {p[10:5], 2'd0};
        b8 = {p[4:0], 3'd0};
      end
      default: begin
        r8 = p[23:16];
        g8 = p[15:8];
        b8 = p[7:0];
      end
    endcase
  end

  // Scale by the factor; only factors below 256 reach this path as fades.
  always_comb begin
    f8     = cfg.fade_factor[7:0];
    r_prod = r8 * f8;
    g_prod = g8 * f8;
    b_prod = b8 * f8;
    rs     = r_prod[15:8];
    gs     = g_prod[15:8];
    bs     = b_prod[15:8];
  end

  // Pack the scaled fields back into the pixel format.
  always_comb begin
    case (cfg.depth_mode)
      DEPTH_RGB332:   faded = {24'd0, rs[7:5], gs[7:5], bs[7:6]};
      DEPTH_RGB555:   faded = {17'd0, rs[7:3], gs[7:3], bs[7:3]};
      DEPTH_RGB565:   faded = {16'd0, rs[7:3], gs[7:2], bs[7:3]};
      default:        faded = {p[31:24], rs, gs, bs};
    endcase
  end

  // Result register contents.
  always_comb begin
    out_nxt.pixel_out  = job.fade ? faded : p;
    out_nxt.in_region  = job.in_region;
    out_nxt.frame_last = job.frame_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;
  assign empty    = !out_valid_r;

endmodule : prf_back

`default_nettype wire

### rtl/core/prf_checker.sv
// ----------------------------------------------------------------------------
// prf_checker: port-level checks of the pixel region fade block
// Watches the request channels of the top level and flags misbehavior.
// ----------------------------------------------------------------------------
`default_nettype none

module prf_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                push,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input prf_pkg::pixel_out_t out_data
);
  import prf_pkg::*;

  // Reset leaves no result waiting and room for input.
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> (empty && !full))
    else $error("results or back-pressure present right after reset");

  // The queue can only fill up behind a waiting result.
  a_full_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !empty)
    else $error("input stalled while no result is waiting");

  // A stalled result stays put.
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("waiting result changed or vanished without a pop");

  // A result taken with no input pending and nothing queued leaves empty.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && pop && !push && !full && $past(!push || full) && $past(empty))
    |=> empty)
    else $error("result appeared without a matching input request");

endmodule : prf_checker

bind pixel_region_fade prf_checker u_prf_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .push     (push),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_data (out_data)
);

`default_nettype wire
